// ===== sv/hob_pkg.sv =====
// ----------------------------------------------------------------------------
// hob_pkg
// Shared types and constants for the horizon occlusion buffer.
// ----------------------------------------------------------------------------
package hob_pkg;

   localparam int COLUMNS_DEFAULT   = 1024;
   localparam int FRAC_BITS_DEFAULT = 4;

   localparam int SLOPE_FRAC = 16;
   localparam int COORD_W    = 16;
   localparam int WIDTH_W    = 11;
   localparam int COUNT_W    = 11;
   localparam int DIV_W      = 48;
   localparam int DIV_CNT_W  = 6;

   localparam logic [WIDTH_W-1:0] ACTIVE_COLUMNS_RESET = 11'd1024;

   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_TEST   = 1'b1;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SETUP,
      ST_DIV_STEP,
      ST_DIV_CLIP,
      ST_LOAD,
      ST_WALK,
      ST_LAST,
      ST_DONE
   } state_type;

endpackage

// ===== sv/horizon_occlusion_buffer.sv =====
// ----------------------------------------------------------------------------
// horizon_occlusion_buffer
// Per-column horizon heights in one RAM; segments are inserted into or tested
// against the horizon one column per cycle.
// ----------------------------------------------------------------------------
//   channel   ports                                   transfer
//   request   start, busy, req_mode, req_start_x/y,   start & !busy
//             req_end_x/y
//   response  rsp_valid, rsp_occluded,                rsp_valid (one cycle)
//             rsp_columns_touched
//   csr       csr_wr_en, csr_wr_data                  csr_wr_en
//
// Off-screen segments go from setup straight to the result; otherwise the walk
// covers N columns, preceded by the slope division when the segment is not
// vertical and by the left clip division when the left end's x is negative. Both
// divisions share one radix-2 divider, one quotient bit per cycle; the walk does
// one RAM read-modify-write per column.
// After reset a clearing pass zeroes every RAM column with busy high.
// The receiver cannot stall; a result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module horizon_occlusion_buffer #(
   parameter int COLUMNS   = hob_pkg::COLUMNS_DEFAULT,
   parameter int FRAC_BITS = hob_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_mode,
   input  logic signed [hob_pkg::COORD_W-1:0]  req_start_x,
   input  logic signed [hob_pkg::COORD_W-1:0]  req_start_y,
   input  logic signed [hob_pkg::COORD_W-1:0]  req_end_x,
   input  logic signed [hob_pkg::COORD_W-1:0]  req_end_y,
   output logic                                rsp_valid,
   output logic                                rsp_occluded,
   output logic        [hob_pkg::COUNT_W-1:0]  rsp_columns_touched,
   input  logic                                csr_wr_en,
   input  logic        [hob_pkg::WIDTH_W-1:0]  csr_wr_data
);
   import hob_pkg::*;

   localparam int COL_W     = $clog2(COLUMNS);
   localparam int WID_W     = COL_W + 1;
   localparam int STEP_BITS = 2*COORD_W + FRAC_BITS;
   localparam int STEP_W    = STEP_BITS + 1;
   localparam int CLIP_W    = 2*COORD_W + 1;
   localparam int ACC_W     = 2*COORD_W + FRAC_BITS + 4;
   localparam int YSH_W     = ACC_W - SLOPE_FRAC;
   localparam int PROD_W    = 2*COORD_W;

   logic signed [COORD_W-1:0] mem [COLUMNS];

   state_type                 state_ff, state_in;
   logic [WIDTH_W-1:0]        active_columns_ff, active_columns_in;
   logic [COL_W-1:0]          clr_addr_ff, clr_addr_in;

   logic                      mode_ff, mode_in;
   logic signed [COORD_W-1:0] sx_ff, sx_in, sy_ff, sy_in, ex_ff, ex_in, ey_ff, ey_in;
   logic [WID_W-1:0]          w_ff, w_in;
   logic [COORD_W-1:0]        dx_ff, dx_in, dy_mag_ff, dy_mag_in, nsx_ff, nsx_in;
   logic                      dy_neg_ff, dy_neg_in, sx_neg_ff, sx_neg_in;
   logic [COL_W-1:0]          col_ff, col_in, last_ff, last_in;
   logic [WID_W-1:0]          count_ff, count_in;
   logic [PROD_W-1:0]         prod_ff;
   logic [COORD_W-1:0]        rem_ff, rem_in;
   logic [DIV_W-1:0]          num_ff, num_in, quo_ff, quo_in;
   logic [DIV_CNT_W-1:0]      cnt_ff, cnt_in;
   logic signed [STEP_W-1:0]  step_ff, step_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic                      p_valid_ff, p_valid_in;
   logic [COL_W-1:0]          p_col_ff, p_col_in;
   logic signed [COORD_W-1:0] p_y_ff, p_y_in;
   logic signed [COORD_W-1:0] rd_data_ff;
   logic                      occ_ff, occ_in;

   logic                      accept;
   logic                      swap;
   logic [31:0]               act_ext;
   logic signed [COORD_W:0]   dx_full, dy_full;
   logic signed [31:0]        sx_ext, w_lim;
   logic                      offscreen;
   logic [COORD_W-1:0]        ex_col;
   logic [WID_W-1:0]          w_m1;
   logic [COL_W-1:0]          col_start;
   logic [COORD_W:0]          div_r2, div_diff;
   logic                      div_ge;
   logic [STEP_W-1:0]         step_mag;
   logic [ACC_W-1:0]          clip_mag;
   logic signed [ACC_W-1:0]   acc_base, clip_term;
   logic signed [YSH_W-1:0]   ysh;
   logic signed [COORD_W-1:0] y_sat;
   logic                      hit;
   logic                      mem_we;
   logic [COL_W-1:0]          mem_waddr;
   logic signed [COORD_W-1:0] mem_wdata;

   assign accept = start && !busy;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_addr_ff == COL_W'(COLUMNS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            if (offscreen) begin
               state_in = ST_DONE;
            end else if (dx_full == '0) begin
               state_in = ST_LOAD;
            end else begin
               state_in = ST_DIV_STEP;
            end
         end
         ST_DIV_STEP: begin
            if (cnt_ff == '0) begin
               state_in = sx_neg_ff ? ST_DIV_CLIP : ST_LOAD;
            end
         end
         ST_DIV_CLIP: begin
            if (cnt_ff == '0) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: state_in = ST_WALK;
         ST_WALK: begin
            if (col_ff == last_ff) begin
               state_in = ST_LAST;
            end
         end
         ST_LAST: state_in = ST_DONE;
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      busy      = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: busy      = 1'b0;
         ST_DONE: rsp_valid = 1'b1;
         default: begin
            busy      = 1'b1;
            rsp_valid = 1'b0;
         end
      endcase
   end

   assign rsp_occluded        = (mode_ff == MODE_TEST) && occ_ff;
   assign rsp_columns_touched = COUNT_W'(count_ff);

   // segment setup
   always_comb begin
      swap      = req_start_x > req_end_x;
      act_ext   = {{(32-WIDTH_W){1'b0}}, active_columns_ff};
      dx_full   = {ex_ff[COORD_W-1], ex_ff} - {sx_ff[COORD_W-1], sx_ff};
      dy_full   = {ey_ff[COORD_W-1], ey_ff} - {sy_ff[COORD_W-1], sy_ff};
      sx_ext    = {{(32-COORD_W){sx_ff[COORD_W-1]}}, sx_ff};
      w_lim     = $signed({{(32-WID_W){1'b0}}, w_ff} << FRAC_BITS);
      offscreen = ex_ff[COORD_W-1] || (sx_ext >= w_lim);
      ex_col    = COORD_W'($unsigned(ex_ff) >> FRAC_BITS);
      w_m1      = w_ff - WID_W'(1);
      col_start = sx_ff[COORD_W-1] ? '0 : COL_W'($unsigned(sx_ff) >> FRAC_BITS);
   end

   // divider and column walk
   always_comb begin
      div_r2    = {rem_ff, num_ff[DIV_W-1]};
      div_diff  = div_r2 - {1'b0, dx_ff};
      div_ge    = div_r2 >= {1'b0, dx_ff};
      step_mag  = {1'b0, quo_ff[STEP_BITS-1:0]};
      clip_mag  = {{(ACC_W-CLIP_W){1'b0}}, quo_ff[CLIP_W-1:0]};
      acc_base  = $signed({{(ACC_W-COORD_W-SLOPE_FRAC){sy_ff[COORD_W-1]}}, sy_ff,
                           {SLOPE_FRAC{1'b0}}});
      clip_term = dy_neg_ff ? -$signed(clip_mag) : $signed(clip_mag);
      ysh       = acc_ff[ACC_W-1:SLOPE_FRAC];
      if (ysh > $signed(YSH_W'(32767))) begin
         y_sat = 16'sh7fff;
      end else if (ysh < -$signed(YSH_W'(32768))) begin
         y_sat = 16'sh8000;
      end else begin
         y_sat = ysh[COORD_W-1:0];
      end
      hit = p_y_ff > rd_data_ff;
   end

   always_comb begin
      active_columns_in = csr_wr_en ? csr_wr_data : active_columns_ff;
      clr_addr_in       = (state_ff == ST_CLEAR) ? clr_addr_ff + COL_W'(1) : clr_addr_ff;

      mode_in   = mode_ff;
      sx_in     = sx_ff;
      sy_in     = sy_ff;
      ex_in     = ex_ff;
      ey_in     = ey_ff;
      w_in      = w_ff;
      dx_in     = dx_ff;
      dy_mag_in = dy_mag_ff;
      dy_neg_in = dy_neg_ff;
      nsx_in    = nsx_ff;
      sx_neg_in = sx_neg_ff;
      col_in    = col_ff;
      last_in   = last_ff;
      count_in  = count_ff;
      rem_in    = rem_ff;
      num_in    = num_ff;
      quo_in    = quo_ff;
      cnt_in    = cnt_ff;
      step_in   = step_ff;
      acc_in    = acc_ff;
      occ_in    = occ_ff;
      p_col_in  = col_ff;
      p_y_in    = y_sat;
      p_valid_in = (state_ff == ST_WALK);

      if (p_valid_ff && (mode_ff == MODE_TEST) && hit) begin
         occ_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               mode_in = req_mode;
               sx_in   = swap ? req_end_x   : req_start_x;
               sy_in   = swap ? req_end_y   : req_start_y;
               ex_in   = swap ? req_start_x : req_end_x;
               ey_in   = swap ? req_start_y : req_end_y;
               occ_in  = 1'b1;
               if (act_ext == '0) begin
                  w_in = WID_W'(1);
               end else if (act_ext > 32'(COLUMNS)) begin
                  w_in = WID_W'(COLUMNS);
               end else begin
                  w_in = WID_W'(act_ext);
               end
            end
         end
         ST_SETUP: begin
            dx_in     = dx_full[COORD_W-1:0];
            dy_neg_in = dy_full[COORD_W];
            dy_mag_in = dy_full[COORD_W] ? COORD_W'(-dy_full) : dy_full[COORD_W-1:0];
            nsx_in    = COORD_W'(-{sx_ff[COORD_W-1], sx_ff});
            sx_neg_in = sx_ff[COORD_W-1];
            col_in    = col_start;
            last_in   = (ex_col > COORD_W'(w_m1)) ? COL_W'(w_m1) : COL_W'(ex_col);
            count_in  = offscreen ? '0 :
                        WID_W'(last_in) - WID_W'(col_start) + WID_W'(1);
            step_in   = '0;
            rem_in    = '0;
            quo_in    = '0;
            num_in    = {dy_mag_in, {(DIV_W-COORD_W){1'b0}}};
            cnt_in    = DIV_CNT_W'(STEP_BITS);
         end
         ST_DIV_STEP, ST_DIV_CLIP: begin
            if (cnt_ff != '0) begin
               rem_in = div_ge ? div_diff[COORD_W-1:0] : div_r2[COORD_W-1:0];
               num_in = {num_ff[DIV_W-2:0], 1'b0};
               quo_in = {quo_ff[DIV_W-2:0], div_ge};
               cnt_in = cnt_ff - DIV_CNT_W'(1);
            end else if (state_ff == ST_DIV_STEP) begin
               step_in = dy_neg_ff ? -$signed(step_mag) : $signed(step_mag);
               rem_in  = '0;
               quo_in  = '0;
               num_in  = {prod_ff, {(DIV_W-PROD_W){1'b0}}};
               cnt_in  = DIV_CNT_W'(DIV_W);
            end
         end
         ST_LOAD: begin
            acc_in = sx_neg_ff ? acc_base + clip_term : acc_base;
         end
         ST_WALK: begin
            acc_in = acc_ff + {{(ACC_W-STEP_W){step_ff[STEP_W-1]}}, step_ff};
            col_in = col_ff + COL_W'(1);
         end
         default: begin
            acc_in = acc_ff;
         end
      endcase
   end

   always_comb begin
      if (state_ff == ST_CLEAR) begin
         mem_we    = 1'b1;
         mem_waddr = clr_addr_ff;
         mem_wdata = '0;
      end else begin
         mem_we    = p_valid_ff && (mode_ff == MODE_INSERT) && hit;
         mem_waddr = p_col_ff;
         mem_wdata = p_y_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[col_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_CLEAR;
         active_columns_ff <= ACTIVE_COLUMNS_RESET;
         clr_addr_ff       <= '0;
         p_valid_ff        <= 1'b0;
      end else begin
         state_ff          <= state_in;
         active_columns_ff <= active_columns_in;
         clr_addr_ff       <= clr_addr_in;
         p_valid_ff        <= p_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff   <= mode_in;
      sx_ff     <= sx_in;
      sy_ff     <= sy_in;
      ex_ff     <= ex_in;
      ey_ff     <= ey_in;
      w_ff      <= w_in;
      dx_ff     <= dx_in;
      dy_mag_ff <= dy_mag_in;
      dy_neg_ff <= dy_neg_in;
      nsx_ff    <= nsx_in;
      sx_neg_ff <= sx_neg_in;
      col_ff    <= col_in;
      last_ff   <= last_in;
      count_ff  <= count_in;
      prod_ff   <= nsx_ff * dy_mag_ff;
      rem_ff    <= rem_in;
      num_ff    <= num_in;
      quo_ff    <= quo_in;
      cnt_ff    <= cnt_in;
      step_ff   <= step_in;
      acc_ff    <= acc_in;
      p_col_ff  <= p_col_in;
      p_y_ff    <= p_y_in;
      occ_ff    <= occ_in;
   end

`ifndef SYNTHESIS
   a_accept_setup: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_SETUP))
      else $error("transfer did not enter setup");

   a_rsp_then_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy)
      else $error("block not idle after result");

   a_insert_not_occluded: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (mode_ff == MODE_INSERT)) |-> !rsp_occluded)
      else $error("insert reported occluded");

   a_walk_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> (col_ff <= last_ff))
      else $error("walk past last column");

   a_write_only_insert: assert property (@(posedge clock) disable iff (reset)
      (mem_we && (state_ff != ST_CLEAR)) |-> (mode_ff == MODE_INSERT))
      else $error("horizon written during test");
`endif

endmodule
